// ===== sv/tmcm_pkg.sv =====
`timescale 1ns / 1ps
package tmcm_pkg;
  localparam int SampleBits = 12;
  localparam int NumSamples = 5;
  localparam int SizeBits = 13;
  localparam int OutBits = 12;
  localparam int ProdBits = SampleBits + SizeBits;
  localparam int DivSteps = ProdBits;
  localparam logic [OutBits-1:0] OutMax = '1;

  typedef enum logic [2:0] {
    REG_X_MIN = 3'd0,
    REG_X_MAX = 3'd1,
    REG_Y_MIN = 3'd2,
    REG_Y_MAX = 3'd3,
    REG_WIDTH = 3'd4,
    REG_HEIGHT = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [SampleBits-1:0] x_sample_0;
    logic [SampleBits-1:0] x_sample_1;
    logic [SampleBits-1:0] x_sample_2;
    logic [SampleBits-1:0] x_sample_3;
    logic [SampleBits-1:0] x_sample_4;
    logic [SampleBits-1:0] y_sample_0;
    logic [SampleBits-1:0] y_sample_1;
    logic [SampleBits-1:0] y_sample_2;
    logic [SampleBits-1:0] y_sample_3;
    logic [SampleBits-1:0] y_sample_4;
  } in_item_t;

  typedef struct packed {
    logic [OutBits-1:0] coord_x;
    logic [OutBits-1:0] coord_y;
  } out_item_t;

  typedef struct packed {
    logic [SampleBits-1:0] lo;
    logic [SampleBits-1:0] hi;
    logic [SizeBits-1:0]   size;
  } axis_cfg_t;
endpackage

// ===== sv/tmcm_median.sv =====
`timescale 1ns / 1ps
module tmcm_median import tmcm_pkg::*; (
  input  logic                  clk,
  input  logic [SampleBits-1:0] s_i [NumSamples],
  output logic [SampleBits-1:0] med_o
);
  // rank count: element k is the median if exactly two of the others are below it (ties by index)
  logic [SampleBits-1:0] med_nxt, med_r;
  always_comb begin
    logic [3:0] below;
    med_nxt = s_i[0];
    for (int k = 0; k < NumSamples; k++) begin
      below = '0;
      for (int j = 0; j < NumSamples; j++) begin
        if (j != k) begin
          if (s_i[j] < s_i[k] || (s_i[j] == s_i[k] && j < k)) below = below + 4'd1;
        end
      end
      if (below == 4'(NumSamples / 2)) med_nxt = s_i[k];
    end
  end
  always_ff @(posedge clk) med_r <= med_nxt;
  assign med_o = med_r;
endmodule

// ===== sv/tmcm_map.sv =====
`timescale 1ns / 1ps
module tmcm_map import tmcm_pkg::*; (
  input  logic                  clk,
  input  logic [SampleBits-1:0] raw_i,
  input  axis_cfg_t             cfg_i,
  output logic [OutBits-1:0]    coord_o
);
  // stage 0: clamp and multiply
  logic [SampleBits-1:0] c;
  logic [SizeBits-1:0]   sz;
  logic [ProdBits-1:0]   num_r;
  logic [SampleBits-1:0] den_r;
  logic [SizeBits-1:0]   lim_r;
  logic                  zero_r;
  always_comb begin
    c = raw_i;
    if (c < cfg_i.lo) c = cfg_i.lo;
    if (c > cfg_i.hi) c = cfg_i.hi;
    sz = (cfg_i.size == '0) ? SizeBits'(1) : cfg_i.size;
  end
  always_ff @(posedge clk) begin
    num_r  <= ProdBits'(cfg_i.hi - c) * ProdBits'(sz - SizeBits'(1));
    den_r  <= cfg_i.hi - cfg_i.lo;
    lim_r  <= sz - SizeBits'(1);
    zero_r <= cfg_i.hi <= cfg_i.lo;
  end
  // restoring divider, one quotient bit per stage
  logic [ProdBits-1:0]   q_r   [DivSteps+1];
  logic [SampleBits:0]   rem_r [DivSteps+1];
  logic [SampleBits-1:0] d_r   [DivSteps+1];
  logic [SizeBits-1:0]   l_r   [DivSteps+1];
  logic                  z_r   [DivSteps+1];
  always_comb begin
    q_r[0] = num_r; rem_r[0] = '0; d_r[0] = den_r; l_r[0] = lim_r; z_r[0] = zero_r;
  end
  for (genvar g = 0; g < DivSteps; g++) begin : g_div
    logic [SampleBits:0] t;
    assign t = {rem_r[g][SampleBits-1:0], q_r[g][ProdBits-1]};
    always_ff @(posedge clk) begin
      if (t >= {1'b0, d_r[g]}) begin
        rem_r[g+1] <= t - {1'b0, d_r[g]};
        q_r[g+1]   <= {q_r[g][ProdBits-2:0], 1'b1};
      end else begin
        rem_r[g+1] <= t;
        q_r[g+1]   <= {q_r[g][ProdBits-2:0], 1'b0};
      end
      d_r[g+1] <= d_r[g];
      l_r[g+1] <= l_r[g];
      z_r[g+1] <= z_r[g];
    end
  end
  logic [ProdBits-1:0] q;
  logic [OutBits-1:0]  coord_r;
  always_comb begin
    q = q_r[DivSteps];
    if (q > ProdBits'(l_r[DivSteps])) q = ProdBits'(l_r[DivSteps]);
    if (q > ProdBits'(OutMax)) q = ProdBits'(OutMax);
  end
  always_ff @(posedge clk) coord_r <= z_r[DivSteps] ? '0 : q[OutBits-1:0];
  assign coord_o = coord_r;
endmodule

// ===== sv/touch_median_coordinate_map.sv =====
`timescale 1ns / 1ps
// touch coordinate mapper
// raise start with in_item for one beat while busy is low; busy is always low, so
// a new beat can enter every cycle. each beat carries five raw x and five raw y
// adc samples. two lanes (x and y) each take a median of five, clamp to the
// calibrated raw range and map it inverted onto the screen size.
// out_valid pulses with out_item once a beat has passed the pipeline: 1 median
// stage, 1 multiply stage, 25 divider stages, 1 clamp stage, 1 output register.
// throughput: one beat per cycle, set by the one-bit-per-stage divider.
// the receiver cannot stall: out_item is valid for exactly the one out_valid cycle.
// reset (rst_n low, synchronous) clears the pipeline valid bits and loads the
// calibration defaults: raw range 0..4095, screen 800 x 480.
// calibration x_min, x_max, y_min, y_max, width, height sits at apb byte offsets
// 0x00..0x14 in that order; the user writes it only while idle; not enforced.
module touch_median_coordinate_map import tmcm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_valid,
  output out_item_t   out_item,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int Lat = DivSteps + 4;

  logic [SampleBits-1:0] xmin_r, xmax_r, ymin_r, ymax_r;
  logic [SizeBits-1:0]   w_r, h_r;
  logic                  wr;
  reg_idx_t              idx;

  assign cfg_pready = 1'b1;
  assign busy = 1'b0;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx = reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xmin_r <= '0; xmax_r <= '1; ymin_r <= '0; ymax_r <= '1;
      w_r <= SizeBits'(800); h_r <= SizeBits'(480);
    end else if (wr) begin
      unique case (idx)
        REG_X_MIN:  xmin_r <= cfg_pwdata[SampleBits-1:0];
        REG_X_MAX:  xmax_r <= cfg_pwdata[SampleBits-1:0];
        REG_Y_MIN:  ymin_r <= cfg_pwdata[SampleBits-1:0];
        REG_Y_MAX:  ymax_r <= cfg_pwdata[SampleBits-1:0];
        REG_WIDTH:  w_r <= cfg_pwdata[SizeBits-1:0];
        REG_HEIGHT: h_r <= cfg_pwdata[SizeBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_X_MIN:  cfg_prdata = 32'(xmin_r);
      REG_X_MAX:  cfg_prdata = 32'(xmax_r);
      REG_Y_MIN:  cfg_prdata = 32'(ymin_r);
      REG_Y_MAX:  cfg_prdata = 32'(ymax_r);
      REG_WIDTH:  cfg_prdata = 32'(w_r);
      REG_HEIGHT: cfg_prdata = 32'(h_r);
      default:    cfg_prdata = '0;
    endcase
  end

  logic [SampleBits-1:0] xs [NumSamples];
  logic [SampleBits-1:0] ys [NumSamples];
  assign xs = '{in_item.x_sample_0, in_item.x_sample_1, in_item.x_sample_2,
                in_item.x_sample_3, in_item.x_sample_4};
  assign ys = '{in_item.y_sample_0, in_item.y_sample_1, in_item.y_sample_2,
                in_item.y_sample_3, in_item.y_sample_4};

  logic [SampleBits-1:0] mx, my;
  logic [OutBits-1:0]    cx, cy;
  axis_cfg_t             xcfg, ycfg;
  assign xcfg = '{lo: xmin_r, hi: xmax_r, size: w_r};
  assign ycfg = '{lo: ymin_r, hi: ymax_r, size: h_r};

  tmcm_median u_med_x (.clk(clk), .s_i(xs), .med_o(mx));
  tmcm_median u_med_y (.clk(clk), .s_i(ys), .med_o(my));
  tmcm_map u_map_x (.clk(clk), .raw_i(mx), .cfg_i(xcfg), .coord_o(cx));
  tmcm_map u_map_y (.clk(clk), .raw_i(my), .cfg_i(ycfg), .coord_o(cy));

  // merge: valid shift line, then one output register for both lanes
  logic [Lat-2:0] vld_r;
  out_item_t      out_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= {vld_r[Lat-3:0], start};
  end
  always_ff @(posedge clk) out_r <= '{coord_x: cx, coord_y: cy};
  logic ov_r;
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else ov_r <= vld_r[Lat-2];
  end
  assign out_valid = ov_r;
  assign out_item = out_r;

  a_out_x_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && w_r != '0 && w_r <= SizeBits'(4096) |->
      SizeBits'(out_item.coord_x) < w_r) else $error("x beyond width");
  a_out_y_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && h_r != '0 && h_r <= SizeBits'(4096) |->
      SizeBits'(out_item.coord_y) < h_r) else $error("y beyond height");
  a_no_busy: assert property (@(posedge clk) !busy) else $error("busy raised");
endmodule
